>>> rtl/s2a_pkg.sv
// Package: shared types, constants and scancode lookup functions for the scancode decoder.
`default_nettype none

package s2a_pkg;

  // Special scancodes (set 1)
  localparam logic [7:0] CodeLShift    = 8'h2A;
  localparam logic [7:0] CodeRShift    = 8'h36;
  localparam logic [7:0] CodeCaps      = 8'h3A;
  localparam logic [7:0] CodeBackspace = 8'h0E;
  localparam logic [7:0] CodeTab       = 8'h0F;
  localparam logic [7:0] ReleaseBit    = 8'h80;

  // Tab expands into a run of spaces
  localparam int TabWidth = 4;
  localparam int CntW     = $clog2(TabWidth);

  localparam logic [6:0] AsciiSpace = 7'h20;
  localparam logic [6:0] AsciiLowA  = 7'h61;
  localparam logic [6:0] AsciiLowZ  = 7'h7A;

  // Result kinds
  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_BKSP = 1'b1
  } kind_t;

  // Decoded item handed from the decode stage to the result register
  typedef struct packed {
    kind_t      kind;
    logic [6:0] char_code;
    logic       tab;
  } res_t;

  // Unshifted character for a make code below 0x40; zero where no character
  function automatic logic [6:0] plain_char(input logic [5:0] idx);
    logic [6:0] c;
    unique case (idx)
      6'h02: c = 7'h31;  6'h03: c = 7'h32;  6'h04: c = 7'h33;  6'h05: c = 7'h34;
      6'h06: c = 7'h35;  6'h07: c = 7'h36;  6'h08: c = 7'h37;  6'h09: c = 7'h38;
      6'h0A: c = 7'h39;  6'h0B: c = 7'h30;  6'h0C: c = 7'h2D;  6'h0D: c = 7'h3D;
      6'h10: c = 7'h71;  6'h11: c = 7'h77;  6'h12: c = 7'h65;  6'h13: c = 7'h72;
      6'h14: c = 7'h74;  6'h15: c = 7'h79;  6'h16: c = 7'h75;  6'h17: c = 7'h69;
      6'h18: c = 7'h6F;  6'h19: c = 7'h70;  6'h1A: c = 7'h5B;  6'h1B: c = 7'h5D;
      6'h1C: c = 7'h0A;  6'h1E: c = 7'h61;  6'h1F: c = 7'h73;
      6'h20: c = 7'h64;  6'h21: c = 7'h66;  6'h22: c = 7'h67;  6'h23: c = 7'h68;
      6'h24: c = 7'h6A;  6'h25: c = 7'h6B;  6'h26: c = 7'h6C;  6'h27: c = 7'h3B;
      6'h28: c = 7'h27;  6'h2B: c = 7'h5C;  6'h2C: c = 7'h7A;  6'h2D: c = 7'h78;
      6'h2E: c = 7'h63;  6'h2F: c = 7'h76;
      6'h30: c = 7'h62;  6'h31: c = 7'h6E;  6'h32: c = 7'h6D;  6'h33: c = 7'h2C;
      6'h34: c = 7'h2E;  6'h35: c = 7'h2F;  6'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_letter(input logic [6:0] c);
    return (c >= AsciiLowA) && (c <= AsciiLowZ);
  endfunction

  // Shifted character; letters map to upper case
  function automatic logic [6:0] shift_char(input logic [5:0] idx);
    logic [6:0] p;
    logic [6:0] c;
    p = plain_char(idx);
    unique case (idx)
      6'h02: c = 7'h21;  6'h03: c = 7'h40;  6'h04: c = 7'h23;  6'h05: c = 7'h24;
      6'h06: c = 7'h25;  6'h07: c = 7'h5E;  6'h08: c = 7'h26;  6'h09: c = 7'h2A;
      6'h0A: c = 7'h28;  6'h0B: c = 7'h29;  6'h0C: c = 7'h5F;  6'h0D: c = 7'h2B;
      6'h1A: c = 7'h7B;  6'h1B: c = 7'h7D;  6'h27: c = 7'h3A;  6'h28: c = 7'h22;
      6'h2B: c = 7'h7C;  6'h33: c = 7'h3C;  6'h34: c = 7'h3E;  6'h35: c = 7'h3F;
      default: c = is_letter(p) ? (p & 7'h5F) : p;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/s2a_in_if.sv
// Interface: scancode input channel.
`default_nettype none

interface s2a_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] scancode;

  modport source (output valid, output scancode, input ready);
  modport sink   (input valid, input scancode, output ready);
endinterface

`default_nettype wire

>>> rtl/s2a_out_if.sv
// Interface: ASCII result channel.
`default_nettype none

interface s2a_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [6:0] char_code;
  logic       last;

  modport source (output valid, output kind, output char_code, output last, input ready);
  modport sink   (input valid, input kind, input char_code, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/s2a_decode.sv
// Input register, shift/caps flags and the combinational scancode decode.
`default_nettype none

module s2a_decode (
  input  wire logic          clk,
  input  wire logic          rst,
  s2a_in_if.sink             scan,
  input  wire logic          take,
  output logic               res_valid,
  output s2a_pkg::res_t      res
);
  import s2a_pkg::*;

  logic       q_valid;
  logic [7:0] code;
  logic       shift_held;
  logic       caps_lock_on;

  logic       has;
  logic       advance;
  logic       shift_set;
  logic       shift_clr;
  logic       caps_tog;
  logic [6:0] plain;
  logic [6:0] shifted;
  logic       upper;

  // Decode the held scancode against the current flags
  always_comb begin
    plain     = plain_char(code[5:0]);
    shifted   = shift_char(code[5:0]);
    upper     = shift_held || (caps_lock_on && is_letter(plain));
    has       = 1'b0;
    shift_set = 1'b0;
    shift_clr = 1'b0;
    caps_tog  = 1'b0;
    res       = '{kind: KIND_CHAR, char_code: upper ? shifted : plain, tab: 1'b0};
    priority if ((code == (CodeLShift | ReleaseBit)) || (code == (CodeRShift | ReleaseBit))) begin
      shift_clr = 1'b1;
    end else if (code[7:6] != 2'b00) begin
      // other release codes and unmapped high codes: nothing
    end else if ((code == CodeLShift) || (code == CodeRShift)) begin
      shift_set = 1'b1;
    end else if (code == CodeCaps) begin
      caps_tog = 1'b1;
    end else if (code == CodeBackspace) begin
      has = 1'b1;
      res = '{kind: KIND_BKSP, char_code: 7'h00, tab: 1'b0};
    end else if (code == CodeTab) begin
      has = 1'b1;
      res = '{kind: KIND_CHAR, char_code: AsciiSpace, tab: 1'b1};
    end else begin
      has = (plain != 7'h00);
    end
  end

  // Items without a result pass straight through; others wait for the result register
  assign advance    = q_valid && (!has || take);
  assign res_valid  = q_valid && has;
  assign scan.ready = !q_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (scan.ready) begin
      q_valid <= scan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      code <= scan.scancode;
    end
  end

  // Modifier flags, updated as each item leaves decode
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held   <= 1'b0;
      caps_lock_on <= 1'b0;
    end else if (advance) begin
      if (shift_set) begin
        shift_held <= 1'b1;
      end else if (shift_clr) begin
        shift_held <= 1'b0;
      end
      if (caps_tog) begin
        caps_lock_on <= !caps_lock_on;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/s2a_emit.sv
// Result register: presents decoded items and repeats the space for a tab run.
`default_nettype none

module s2a_emit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          res_valid,
  input  wire s2a_pkg::res_t res,
  output logic               take,
  s2a_out_if.source          ascii
);
  import s2a_pkg::*;

  logic            valid;
  logic [CntW-1:0] cnt;
  logic            done;

  // Free once the final result of the current run is taken
  assign done          = ascii.valid && ascii.ready;
  assign take          = !valid || (done && (cnt == '0));
  assign ascii.valid   = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      cnt   <= '0;
    end else if (take && res_valid) begin
      valid <= 1'b1;
      cnt   <= res.tab ? CntW'(TabWidth - 1) : '0;
    end else if (done) begin
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end else begin
        valid <= 1'b0;
      end
    end
  end

  // Payload; last rises on the final space of a tab run
  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      ascii.kind      <= res.kind;
      ascii.char_code <= res.char_code;
      ascii.last      <= !res.tab;
    end else if (done && (cnt != '0)) begin
      ascii.last      <= (cnt == CntW'(1));
    end
  end

`ifndef SYNTHESIS
  a_run_not_last: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) |-> (valid && !ascii.last && (ascii.char_code == AsciiSpace)))
    else $error("tab run pending but result marked last");

  a_notlast_has_run: assert property (@(posedge clk) disable iff (rst)
    (valid && !ascii.last) |-> (cnt != '0))
    else $error("result not last without remaining run");

  a_run_steps: assert property (@(posedge clk) disable iff (rst)
    (done && (cnt != '0)) |=> (valid && (cnt == $past(cnt) - 1'b1)))
    else $error("tab run did not step correctly");

  a_bksp_shape: assert property (@(posedge clk) disable iff (rst)
    (valid && (ascii.kind == KIND_BKSP)) |-> ((ascii.char_code == 7'h00) && ascii.last))
    else $error("backspace result malformed");
`endif

endmodule

`default_nettype wire

>>> rtl/scancode_to_ascii_decoder_core.sv
// Path: a scancode passes the input register and then the result register before its first result shows.
// Throughput: one scancode per cycle while the output is ready and no tab run is pending; a tab holds
// the result register while its four spaces go out, and later scancodes wait in the input register.
// Scancodes with no result leave decode without using the result register.
// Reset (synchronous, active high) clears shift held, caps lock and both valid flags.
`default_nettype none

module scancode_to_ascii_decoder_core (
  input  wire logic clk,
  input  wire logic rst,
  s2a_in_if.sink    scan,
  s2a_out_if.source ascii
);
  import s2a_pkg::*;

  logic res_valid;
  res_t res;
  logic take;

  s2a_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .scan      (scan),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  s2a_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .take      (take),
    .ascii     (ascii)
  );

endmodule

`default_nettype wire
